/* design/srl2n_pkg.sv */
`timescale 1ns / 1ps
package srl2n_pkg;

  // Fixed field and arithmetic widths.
  localparam int unsigned ValW  = 24;
  localparam int unsigned CntW  = 7;
  localparam int unsigned SumW  = 53;
  localparam int unsigned NormW = 27;
  localparam int unsigned OutW  = 16;

  // Status codes carried with every emitted entry.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Row descriptor passed from the front to the back.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [SumW-1:0] sum;
    logic            ovf;
  } row_desc_t;

endpackage

/* design/srl2n_ram.sv */
`timescale 1ns / 1ps
module srl2n_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/srl2n_queue.sv */
`timescale 1ns / 1ps
module srl2n_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  srl2n_pkg::row_desc_t push_data_i,
  input  logic                pop_i,
  output srl2n_pkg::row_desc_t pop_data_o,
  output logic                empty_o
);
  import srl2n_pkg::*;

  row_desc_t slot_q [2];
  logic      wptr_q, rptr_q;
  logic [1:0] fill_q;

  assign pop_data_o = slot_q[rptr_q];
  assign empty_o    = (fill_q == 2'd0);

  // Two-entry descriptor FIFO; the front never pushes when it is full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* design/srl2n_front.sv */
`timescale 1ns / 1ps
module srl2n_front #(
  parameter int unsigned MaxRowEntries = 64,
  parameter int unsigned ColumnWidth   = 20,
  parameter int unsigned AddrW         = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [srl2n_pkg::ValW-1:0]  entry_value_i,
  input  logic [ColumnWidth-1:0]             column_index_i,
  input  logic                               row_end_i,
  input  logic                               row_done_i,
  output logic                               we_o,
  output logic [AddrW-1:0]                   waddr_o,
  output logic [srl2n_pkg::ValW+ColumnWidth-1:0] wdata_o,
  output logic                               push_o,
  output srl2n_pkg::row_desc_t               push_data_o
);
  import srl2n_pkg::*;

  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic            ovf_q, ovf_d;
  logic            bank_q;
  logic [1:0]      busy_q;
  logic            accept, store;
  logic signed [2*ValW-1:0] prod;

  // Two buffer banks: a new row may load while up to one row is in the back.
  assign in_ready_o = (busy_q != 2'd2);
  assign accept     = in_valid_i && in_ready_o;
  assign store      = (count_q < CntW'(MaxRowEntries));
  assign prod       = entry_value_i * entry_value_i;

  assign we_o    = accept && store;
  assign waddr_o = {bank_q, count_q[AddrW-2:0]};
  assign wdata_o = {entry_value_i, column_index_i};

  // Running count, sum of squares and overflow mark including this entry.
  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    if (store) begin
      count_d = count_q + CntW'(1);
      sum_d   = sum_q + SumW'(unsigned'(prod));
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign push_o           = accept && row_end_i;
  assign push_data_o.cnt  = count_d;
  assign push_data_o.sum  = sum_d;
  assign push_data_o.ovf  = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
      busy_q  <= 2'd0;
    end else begin
      if (accept) begin
        if (row_end_i) begin
          count_q <= '0;
          sum_q   <= '0;
          ovf_q   <= 1'b0;
          bank_q  <= ~bank_q;
        end else begin
          count_q <= count_d;
          sum_q   <= sum_d;
          ovf_q   <= ovf_d;
        end
      end
      busy_q <= busy_q + {1'b0, push_o} - {1'b0, row_done_i};
    end
  end

endmodule

/* design/srl2n_back.sv */
`timescale 1ns / 1ps
module srl2n_back #(
  parameter int unsigned ColumnWidth = 20,
  parameter int unsigned AddrW       = 7
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_empty_i,
  input  srl2n_pkg::row_desc_t                   q_data_i,
  output logic                                   q_pop_o,
  output logic [AddrW-1:0]                       raddr_o,
  input  logic [srl2n_pkg::ValW+ColumnWidth-1:0] rdata_i,
  output logic                                   row_done_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [srl2n_pkg::OutW-1:0]      normalized_value_o,
  output logic [ColumnWidth-1:0]                 column_out_o,
  output logic                                   row_last_o,
  output logic [1:0]                             status_code_o
);
  import srl2n_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT, ST_READ, ST_WAIT, ST_DIV, ST_EMIT
  } state_e;

  state_e            state_q;
  logic              bank_q;
  logic [CntW-1:0]   cnt_q, idx_q;
  logic              ovf_q;
  logic [SumW-1:0]   x_q, res_q, bit_q;
  logic [SumW:0]     trial;
  logic [NormW-1:0]  norm;
  logic [4:0]        step_q;
  logic [NormW:0]    rem_q, rem_sh;
  logic [15:0]       nlow_q, quo_q;
  logic              sat_q, neg_q;
  logic [ColumnWidth-1:0] col_q;
  logic signed [ValW-1:0] v;
  logic [ValW-1:0]   mag;
  logic [39:0]       dividend;
  logic [16:0]       qmag;
  logic signed [OutW-1:0] value;
  logic [1:0]        status;
  logic              emit;

  assign raddr_o = {bank_q, idx_q[AddrW-2:0]};
  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;

  // Square root step and the norm it settles on.
  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign norm  = res_q[NormW-1:0];

  // Rounded dividend for the entry just read.
  assign v        = rdata_i[ValW+ColumnWidth-1:ColumnWidth];
  assign mag      = v[ValW-1] ? ValW'(-v) : ValW'(v);
  assign dividend = {1'b0, mag, 15'b0} + 40'({1'b0, norm[NormW-1:1]});

  // Restoring division step.
  assign rem_sh = {rem_q[NormW-1:0], nlow_q[15]};

  // Saturation and sign for the emitted value.
  always_comb begin
    qmag = sat_q ? 17'h1ffff : {1'b0, quo_q};
    if (norm == '0) begin
      value = '0;
    end else if (!neg_q) begin
      value = (qmag > 17'd32767) ? OutW'(32767) : OutW'(qmag);
    end else begin
      value = (qmag > 17'd32768) ? OutW'(17'h10000 - 17'd32768)
                                 : OutW'(17'h10000 - qmag);
    end
    status = ovf_q ? STATUS_OVERFLOW : ((norm == '0) ? STATUS_ZERO : STATUS_OK);
  end

  assign emit       = (state_q == ST_EMIT) && (!out_valid_o || out_ready_i);
  assign row_done_o = emit && (idx_q + CntW'(1) == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && !emit) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (bit_q == '0) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: state_q <= ST_WAIT;
        ST_WAIT: state_q <= ST_DIV;
        ST_DIV: begin
          if (step_q == 5'd15) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            out_valid_o <= 1'b1;
            if (row_done_o) begin
              bank_q  <= ~bank_q;
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        cnt_q <= q_data_i.cnt;
        ovf_q <= q_data_i.ovf;
        x_q   <= q_data_i.sum;
        res_q <= '0;
        bit_q <= SumW'(1) << (SumW - 1);
        idx_q <= '0;
      end
      ST_SQRT: begin
        if (bit_q != '0) begin
          if ({1'b0, x_q} >= trial) begin
            x_q   <= x_q - trial[SumW-1:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      ST_WAIT: begin
        neg_q  <= v[ValW-1];
        col_q  <= rdata_i[ColumnWidth-1:0];
        sat_q  <= ({3'b0, dividend} >= {norm, 16'b0});
        rem_q  <= (NormW+1)'(dividend[39:16]);
        nlow_q <= dividend[15:0];
        step_q <= '0;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, norm}) begin
          rem_q <= rem_sh - {1'b0, norm};
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[14:0], 1'b0};
        end
        nlow_q <= {nlow_q[14:0], 1'b0};
        step_q <= step_q + 5'd1;
      end
      ST_EMIT: begin
        if (emit) begin
          normalized_value_o <= value;
          column_out_o       <= col_q;
          row_last_o         <= row_done_o;
          status_code_o      <= status;
          idx_q              <= idx_q + CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/sparse_row_l2_normalizer_top.sv */
`timescale 1ns / 1ps
// Entries are accepted one per cycle while a buffer bank is free (two banks).
// At row end the back takes the square root of the sum, then handles the stored entries
// one at a time (RAM read, 16-step division, output register), stalling while out_ready_i is low.
// rst_ni clears all control state asynchronously; buffer contents are not cleared.
module sparse_row_l2_normalizer_top #(
  parameter int unsigned MAX_ROW_ENTRIES = 64,
  parameter int unsigned COLUMN_WIDTH    = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [srl2n_pkg::ValW-1:0] entry_value_i,
  input  logic [COLUMN_WIDTH-1:0]           column_index_i,
  input  logic                              row_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [srl2n_pkg::OutW-1:0] normalized_value_o,
  output logic [COLUMN_WIDTH-1:0]           column_out_o,
  output logic                              row_last_o,
  output logic [1:0]                        status_code_o
);
  import srl2n_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_ROW_ENTRIES) + 1;
  localparam int unsigned DataW = ValW + COLUMN_WIDTH;

  logic             we, push, pop, q_empty, row_done;
  logic [AddrW-1:0] waddr, raddr;
  logic [DataW-1:0] wdata, rdata;
  row_desc_t        push_data, pop_data;

  // Front: buffers entries and builds one descriptor per row.
  srl2n_front #(
    .MaxRowEntries(MAX_ROW_ENTRIES),
    .ColumnWidth  (COLUMN_WIDTH),
    .AddrW        (AddrW)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .entry_value_i, .column_index_i, .row_end_i,
    .row_done_i (row_done),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .push_o     (push),
    .push_data_o(push_data)
  );

  // Entry buffer, two banks, each of 2**(AddrW-1) entries, enough for MAX_ROW_ENTRIES.
  srl2n_ram #(
    .Width(DataW),
    .Depth(2 ** AddrW)
  ) u_ram (
    .clk_i,
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Row descriptor queue between front and back.
  srl2n_queue u_queue (
    .clk_i, .rst_ni,
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (q_empty)
  );

  // Back: square root, per-entry division and result register.
  srl2n_back #(
    .ColumnWidth(COLUMN_WIDTH),
    .AddrW      (AddrW)
  ) u_back (
    .clk_i, .rst_ni,
    .q_empty_i (q_empty),
    .q_data_i  (pop_data),
    .q_pop_o   (pop),
    .raddr_o   (raddr),
    .rdata_i   (rdata),
    .row_done_o(row_done),
    .out_valid_o, .out_ready_i,
    .normalized_value_o, .column_out_o, .row_last_o, .status_code_o
  );

endmodule
